### rtl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared widths, register indexes and types for the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

	// data path format: signed integers, gains signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;

	// derived widths
	localparam int ERR_W   = DATA_WIDTH + 1;          // setpoint - measurement
	localparam int DERR_W  = DATA_WIDTH + 2;          // error - previous error
	localparam int PROD_W  = DATA_WIDTH + ERR_W;      // gain * error
	localparam int DPROD_W = DATA_WIDTH + DERR_W;     // gain * error delta
	localparam int INTEG_W = DATA_WIDTH + FRAC_BITS + 1; // clamped integral
	localparam int ACC_W   = PROD_W + 2;              // integral before clamp
	localparam int CTRL_W  = DPROD_W + 3;             // p + i + d, negated

	// configuration port
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_TARGET_VALUE = 3'd3,
		REG_MIN_OUT      = 3'd4,
		REG_MAX_OUT      = 3'd5,
		REG_HOLD_OFF     = 3'd6,
		REG_REVERSE_MODE = 3'd7
	} cfg_reg_t;

endpackage

### rtl/pid_controller_clamped_core.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_core
// Fixed point PID controller with integral anti-windup and output clamping.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------
//  input     in         in_valid / in_stall    measured_value  (s16)
//  output    out        out_valid / out_stall  drive_value     (s16)
//  config    in         wr_en (no wait)        wr_index (3b), wr_data (s16)
//
//  one request is accepted per cycle unless in_stall is high; each one gives one result after
//  five register stages: input, error, products, integral, output
//  two loops: previous error, and integral add plus clamp
//  arst_n clears all valids and the controller state, configuration registers take reset values
//  a stall on the output backs up stage by stage; bubbles are squeezed out,
//  so in_stall rises only when every stage holds a request
//
module pid_controller_clamped_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  wr_en,
	input  logic [pidc_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [pidc_pkg::DATA_WIDTH-1:0]       wr_data,
	// measurement requests
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [pidc_pkg::DATA_WIDTH-1:0] measured_value,
	// drive results
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [pidc_pkg::DATA_WIDTH-1:0] drive_value
);

	localparam int DW  = pidc_pkg::DATA_WIDTH;
	localparam int FB  = pidc_pkg::FRAC_BITS;
	localparam int EW  = pidc_pkg::ERR_W;
	localparam int DEW = pidc_pkg::DERR_W;
	localparam int PW  = pidc_pkg::PROD_W;
	localparam int DPW = pidc_pkg::DPROD_W;
	localparam int IW  = pidc_pkg::INTEG_W;
	localparam int AW  = pidc_pkg::ACC_W;
	localparam int CW  = pidc_pkg::CTRL_W;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic signed [DW-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, target_value_q;
	logic signed [DW-1:0] min_out_q, max_out_q;
	logic                 hold_off_q, reverse_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			target_value_q <= '0;
			min_out_q      <= {1'b1, {(DW-1){1'b0}}};
			max_out_q      <= {1'b0, {(DW-1){1'b1}}};
			hold_off_q     <= 1'b1;
			reverse_mode_q <= 1'b0;
		end else if (wr_en) begin
			case (pidc_pkg::cfg_reg_t'(wr_index))
				pidc_pkg::REG_PROP_GAIN:    prop_gain_q    <= wr_data;
				pidc_pkg::REG_INTEG_GAIN:   integ_gain_q   <= wr_data;
				pidc_pkg::REG_DERIV_GAIN:   deriv_gain_q   <= wr_data;
				pidc_pkg::REG_TARGET_VALUE: target_value_q <= wr_data;
				pidc_pkg::REG_MIN_OUT:      min_out_q      <= wr_data;
				pidc_pkg::REG_MAX_OUT:      max_out_q      <= wr_data;
				pidc_pkg::REG_HOLD_OFF:     hold_off_q     <= wr_data[0];
				pidc_pkg::REG_REVERSE_MODE: reverse_mode_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage valids and the ready chain (a stage takes a request when it is
	// empty or its contents move on)
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || !out_stall;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: input register, hold flag taken along with the sample
	// ------------------------------------------------------------------
	logic signed [DW-1:0] meas_s1;
	logic                 hold_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			meas_s1 <= measured_value;
			hold_s1 <= hold_off_q;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: error and error delta; previous error moves only on
	// enabled requests
	// ------------------------------------------------------------------
	logic signed [EW-1:0]  err_c;
	logic signed [DEW-1:0] derr_c;
	logic signed [EW-1:0]  prev_err_q;
	logic signed [EW-1:0]  err_s2;
	logic signed [DEW-1:0] derr_s2;
	logic                  hold_s2;

	assign err_c  = EW'(target_value_q) - EW'(meas_s1);
	assign derr_c = DEW'(err_c) - DEW'(prev_err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
		end else if (v_s1 && rdy2 && !hold_s1) begin
			prev_err_q <= err_c;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy2) begin
			err_s2  <= err_c;
			derr_s2 <= derr_c;
			hold_s2 <= hold_s1;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: the three gain products, one multiplier each
	// ------------------------------------------------------------------
	logic signed [PW-1:0]  p_s3, i_s3;
	logic signed [DPW-1:0] d_s3;
	logic                  hold_s3;

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			p_s3    <= PW'(prop_gain_q) * PW'(err_s2);
			i_s3    <= PW'(integ_gain_q) * PW'(err_s2);
			d_s3    <= DPW'(deriv_gain_q) * DPW'(derr_s2);
			hold_s3 <= hold_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: integral accumulate with clamp (upper limit tested first), and the p plus d sum;
	// an inactive integral starts again from zero
	// ------------------------------------------------------------------
	logic signed [AW-1:0] int_lo_f, int_hi_f, int_base, int_sum;
	logic signed [IW-1:0] int_next;
	logic signed [IW-1:0] integ_q;
	logic                 live_q;
	logic signed [CW-1:0] pd_s4;
	logic                 hold_s4;

	assign int_lo_f = AW'(min_out_q) <<< FB;
	assign int_hi_f = AW'(max_out_q) <<< FB;
	assign int_base = live_q ? AW'(integ_q) : '0;
	assign int_sum  = int_base + AW'(i_s3);

	always_comb begin
		if (int_sum > int_hi_f) begin
			int_next = IW'(int_hi_f);
		end else if (int_sum < int_lo_f) begin
			int_next = IW'(int_lo_f);
		end else begin
			int_next = IW'(int_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			live_q  <= 1'b0;
		end else if (v_s3 && rdy4) begin
			if (hold_s3) begin
				live_q <= 1'b0;
			end else begin
				integ_q <= int_next;
				live_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy4) begin
			pd_s4   <= CW'(p_s3) + CW'(d_s3);
			hold_s4 <= hold_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 5: control sum, optional negation with mirrored limits, clamp
	// (lower limit first), floor to integer and saturation, or zero when held off
	// integ_q still holds this request's integral while it sits in stage 4
	// ------------------------------------------------------------------
	logic signed [CW-1:0] ctrl_sum, ctrl_dir, lo_f, hi_f, lo_sel, hi_sel, ctrl_clamp;
	logic signed [CW-1:0] ctrl_int;
	logic signed [DW-1:0] drive_c;
	logic signed [DW-1:0] drive_s5;

	assign ctrl_sum = pd_s4 + CW'(integ_q);
	assign lo_f     = CW'(min_out_q) <<< FB;
	assign hi_f     = CW'(max_out_q) <<< FB;
	assign ctrl_dir = reverse_mode_q ? -ctrl_sum : ctrl_sum;
	assign lo_sel   = reverse_mode_q ? -hi_f : lo_f;
	assign hi_sel   = reverse_mode_q ? -lo_f : hi_f;

	always_comb begin
		if (ctrl_dir < lo_sel) begin
			ctrl_clamp = lo_sel;
		end else if (ctrl_dir > hi_sel) begin
			ctrl_clamp = hi_sel;
		end else begin
			ctrl_clamp = ctrl_dir;
		end
	end

	// arithmetic shift right is floor
	assign ctrl_int = ctrl_clamp >>> FB;

	always_comb begin
		if (hold_s4) begin
			drive_c = '0;
		end else if ((&ctrl_int[CW-1:DW-1]) || !(|ctrl_int[CW-1:DW-1])) begin
			drive_c = ctrl_int[DW-1:0];
		end else if (ctrl_int[CW-1]) begin
			drive_c = {1'b1, {(DW-1){1'b0}}};
		end else begin
			drive_c = {1'b0, {(DW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && rdy5) begin
			drive_s5 <= drive_c;
		end
	end

	assign out_valid   = v_s5;
	assign drive_value = drive_s5;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// back-pressure only when the whole pipeline is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input stalled while a stage is empty");

	// a blocked integral stage keeps its request
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rdy5) |=> (v_s4 && $stable(pd_s4) && $stable(integ_q)))
		else $error("stage 4 lost its contents under stall");

	// a held-off request marks the integral inactive
	a_hold_clears_live: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy4 && hold_s3) |=> !live_q)
		else $error("integral still live after a held-off request");

	// an enabled request leaves the integral live
	a_enable_sets_live: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && rdy4 && !hold_s3) |=> live_q)
		else $error("integral not live after an enabled request");

endmodule

### tb/tb_pid_controller_clamped_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_controller_clamped_core
// Self-checking bench for the clamped PID core: a directed script of settings
// and measurements, then randomized phases. Every drive value is checked
// against a typed value or an in-bench fixed point model of the controller.
// ----------------------------------------------------------------------------
module tb_pid_controller_clamped_core;

	localparam int DATA_WIDTH  = pidc_pkg::DATA_WIDTH;
	localparam int FRAC_BITS   = pidc_pkg::FRAC_BITS;
	localparam int CLK_PERIOD  = 12;
	localparam int PHASES      = 23;
	localparam int PHASE_ITEMS = 50;
	localparam int SAMPLE_MAX  = 32767;
	localparam int SAMPLE_MIN  = -32768;

	// one line of the directed script: a register write or a measurement
	typedef struct {
		bit                           is_wr;
		pidc_pkg::cfg_reg_t           idx;
		logic [DATA_WIDTH-1:0]        data;
		logic signed [DATA_WIDTH-1:0] meas;
		bit                           typed;
		logic signed [DATA_WIDTH-1:0] want;
	} script_row_t;

	// dut signals; the ones the bench drives are known from time zero
	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         wr_en          = 1'b0;
	pidc_pkg::cfg_reg_t           wr_index       = pidc_pkg::REG_PROP_GAIN;
	logic [DATA_WIDTH-1:0]        wr_data        = '0;
	logic                         in_valid       = 1'b0;
	logic                         in_stall;
	logic signed [DATA_WIDTH-1:0] measured_value = '0;
	logic                         out_valid;
	logic                         out_stall      = 1'b0;
	logic signed [DATA_WIDTH-1:0] drive_value;

	// controller settings as the bench believes them, at their reset values
	logic signed [DATA_WIDTH-1:0] kp_q       = '0;
	logic signed [DATA_WIDTH-1:0] ki_q       = '0;
	logic signed [DATA_WIDTH-1:0] kd_q       = '0;
	logic signed [DATA_WIDTH-1:0] setpoint_q = '0;
	logic signed [DATA_WIDTH-1:0] lo_lim_q   = 16'sh8000;
	logic signed [DATA_WIDTH-1:0] hi_lim_q   = 16'sh7FFF;
	logic                         hold_q     = 1'b1;
	logic                         rev_q      = 1'b0;

	// controller state: integral with FRAC_BITS fraction bits, last error
	longint integ_acc = 0;
	longint last_err  = 0;
	bit     integ_on  = 1'b0;

	// drive values still owed by the dut, oldest first
	logic signed [DATA_WIDTH-1:0] pending_drive [$];
	script_row_t                  script_q [$];
	int                           mismatch_count = 0;
	int                           burst_left     = 0;
	bit                           cfg_open       = 1'b0;

	// receiver stall pattern state
	int          stall_mode = 0;
	int          stall_left = 0;
	logic [7:0]  stall_tick = '0;

	pid_controller_clamped_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.measured_value (measured_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.drive_value    (drive_value)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#3600000;
		$display("pid_controller_clamped_core verification failed");
		$finish;
	end

	// fixed point controller: advances the state by one measurement and
	// returns the drive value it should produce
	function automatic logic signed [DATA_WIDTH-1:0] predict_drive(
			logic signed [DATA_WIDTH-1:0] meas);
		longint err, lo_f, hi_f, ctrl, swap, res;
		// held off: zero out, integral marked stale, history untouched
		if (hold_q) begin
			integ_on = 1'b0;
			return '0;
		end
		err  = longint'(setpoint_q) - longint'(meas);
		lo_f = longint'(lo_lim_q) * (longint'(1) << FRAC_BITS);
		hi_f = longint'(hi_lim_q) * (longint'(1) << FRAC_BITS);
		// first enabled step starts the integral from zero
		if (!integ_on) begin
			integ_acc = 0;
			integ_on  = 1'b1;
		end
		// anti-windup: upper limit checked first, matters for crossed limits
		integ_acc += longint'(ki_q) * err;
		if (integ_acc > hi_f) begin
			integ_acc = hi_f;
		end else if (integ_acc < lo_f) begin
			integ_acc = lo_f;
		end
		ctrl = longint'(kp_q) * err + integ_acc + longint'(kd_q) * (err - last_err);
		last_err = err;
		// reverse acting: negate and mirror the window
		if (rev_q) begin
			swap = lo_f;
			ctrl = -ctrl;
			lo_f = -hi_f;
			hi_f = -swap;
		end
		// output clamp tests the lower limit first
		if (ctrl < lo_f) begin
			ctrl = lo_f;
		end else if (ctrl > hi_f) begin
			ctrl = hi_f;
		end
		// floor to integer, then saturate (mirrored -min can reach +32768)
		res = ctrl >>> FRAC_BITS;
		if (res > SAMPLE_MAX) begin
			res = longint'(SAMPLE_MAX);
		end else if (res < SAMPLE_MIN) begin
			res = longint'(SAMPLE_MIN);
		end
		return res[DATA_WIDTH-1:0];
	endfunction

	function automatic logic signed [DATA_WIDTH-1:0] to_sample(int v);
		if (v > SAMPLE_MAX) begin
			return DATA_WIDTH'(SAMPLE_MAX);
		end else if (v < SAMPLE_MIN) begin
			return DATA_WIDTH'(SAMPLE_MIN);
		end
		return v[DATA_WIDTH-1:0];
	endfunction

	// gains: extremes, full range, or small enough to keep the loop linear
	function automatic logic [DATA_WIDTH-1:0] pick_gain();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4: return DATA_WIDTH'($urandom_range(0, 65535));
			default: return DATA_WIDTH'(int'($urandom_range(0, 1024)) - 512);
		endcase
	endfunction

	// measurements mostly hover around the setpoint, some span the full range
	function automatic logic signed [DATA_WIDTH-1:0] pick_measure();
		if ($urandom_range(0, 4) == 0) begin
			return DATA_WIDTH'($urandom_range(0, 65535));
		end
		return to_sample(int'(setpoint_q) + int'($urandom_range(0, 4000)) - 2000);
	endfunction

	function automatic script_row_t wr_row(pidc_pkg::cfg_reg_t idx,
			logic [DATA_WIDTH-1:0] data);
		script_row_t r;
		r = '{1'b1, idx, data, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic script_row_t item_row(logic signed [DATA_WIDTH-1:0] meas, bit typed,
			logic signed [DATA_WIDTH-1:0] want);
		script_row_t r;
		r = '{1'b0, pidc_pkg::REG_PROP_GAIN, '0, meas, typed, want};
		return r;
	endfunction

	// register write; wr_en stays high until the next request goes out
	task automatic write_reg(pidc_pkg::cfg_reg_t idx, logic [DATA_WIDTH-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			pidc_pkg::REG_PROP_GAIN:    kp_q       = data;
			pidc_pkg::REG_INTEG_GAIN:   ki_q       = data;
			pidc_pkg::REG_DERIV_GAIN:   kd_q       = data;
			pidc_pkg::REG_TARGET_VALUE: setpoint_q = data;
			pidc_pkg::REG_MIN_OUT:      lo_lim_q   = data;
			pidc_pkg::REG_MAX_OUT:      hi_lim_q   = data;
			pidc_pkg::REG_HOLD_OFF:     hold_q     = data[0];
			pidc_pkg::REG_REVERSE_MODE: rev_q      = data[0];
			default: ;
		endcase
		cfg_open = 1'b1;
	endtask

	// one measurement request; bursts of back-to-back requests with random
	// gaps in between, valid held through any stall
	task automatic send_measure(logic signed [DATA_WIDTH-1:0] meas, bit typed,
			logic signed [DATA_WIDTH-1:0] want);
		int gap;
		logic signed [DATA_WIDTH-1:0] model_out;
		if (cfg_open) begin
			@(negedge clk);
			wr_en    <= 1'b0;
			cfg_open = 1'b0;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				@(negedge clk);
				in_valid       <= 1'b0;
				// payload is free to wander while valid is low
				measured_value <= DATA_WIDTH'($urandom_range(0, 65535));
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid       <= 1'b1;
		measured_value <= meas;
		do @(posedge clk); while (in_stall);
		// accepted: advance the model and queue what must come out
		model_out = predict_drive(meas);
		pending_drive.push_back(typed ? want : model_out);
	endtask

	// stop sending and let every owed result come out
	task automatic wait_idle();
		@(negedge clk);
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_drive.size() != 0) @(posedge clk);
	endtask

	// receiver: free running, light random, periodic and heavy stall stretches
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 300);
		end
		stall_left--;
		stall_tick = stall_tick + 8'd1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= stall_tick[2] & stall_tick[0];
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// result checker: every accepted drive value against the oldest owed one
	always @(posedge clk) begin : drive_check
		logic signed [DATA_WIDTH-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_drive.size() == 0) begin
				$display("%0t: drive_value %0d arrived with no request owed",
					$time, drive_value);
				mismatch_count++;
			end else begin
				want = pending_drive.pop_front();
				if (drive_value !== want) begin
					$display("%0t: drive_value expected %0d, got %0d",
						$time, want, drive_value);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int lo_pick, hi_pick, a, b;
		logic [DATA_WIDTH-1:0] flag_word;

		// directed script; values typed only where they are obvious
		// held off after reset: zero whatever comes in
		script_q.push_back(item_row(16'sh7FFF, 1'b1, 16'sh0000));
		script_q.push_back(item_row(16'sh8000, 1'b1, 16'sh0000));
		// enabled with zero gains
		script_q.push_back(wr_row(pidc_pkg::REG_HOLD_OFF, 16'h0000));
		script_q.push_back(item_row(16'sh0000, 1'b1, 16'sh0000));
		// most negative gain, largest error: pinned to the lower limit
		script_q.push_back(wr_row(pidc_pkg::REG_PROP_GAIN, 16'h8000));
		script_q.push_back(wr_row(pidc_pkg::REG_TARGET_VALUE, 16'h7FFF));
		script_q.push_back(item_row(16'sh8000, 1'b1, 16'sh8000));
		script_q.push_back(item_row(16'sh7FFF, 1'b1, 16'sh0000));
		// reverse: mirrored lower limit of +32768 saturates
		script_q.push_back(wr_row(pidc_pkg::REG_REVERSE_MODE, 16'h0001));
		script_q.push_back(item_row(16'sh8000, 1'b1, 16'sh7FFF));
		// reverse, positive gain: pinned to minus max_out
		script_q.push_back(wr_row(pidc_pkg::REG_PROP_GAIN, 16'h7FFF));
		script_q.push_back(item_row(16'sh8000, 1'b1, -16'sd32767));
		// ordinary pid with a narrow window, integral runs into its limit
		script_q.push_back(wr_row(pidc_pkg::REG_PROP_GAIN, 16'h0100));
		script_q.push_back(wr_row(pidc_pkg::REG_INTEG_GAIN, 16'h0080));
		script_q.push_back(wr_row(pidc_pkg::REG_DERIV_GAIN, 16'h0040));
		script_q.push_back(wr_row(pidc_pkg::REG_TARGET_VALUE, 16'd1000));
		script_q.push_back(wr_row(pidc_pkg::REG_MIN_OUT, 16'hFF00));
		script_q.push_back(wr_row(pidc_pkg::REG_MAX_OUT, 16'd500));
		script_q.push_back(wr_row(pidc_pkg::REG_REVERSE_MODE, 16'h0000));
		script_q.push_back(item_row(16'sd900, 1'b0, '0));
		script_q.push_back(item_row(16'sd950, 1'b0, '0));
		script_q.push_back(item_row(16'sd1000, 1'b0, '0));
		script_q.push_back(item_row(16'sd1100, 1'b0, '0));
		script_q.push_back(item_row(16'sd0, 1'b0, '0));
		// hold off, then re-enable: integral restarts, last error kept
		script_q.push_back(wr_row(pidc_pkg::REG_HOLD_OFF, 16'h0001));
		script_q.push_back(item_row(16'sd123, 1'b1, 16'sh0000));
		script_q.push_back(wr_row(pidc_pkg::REG_HOLD_OFF, 16'h0000));
		script_q.push_back(item_row(16'sd990, 1'b0, '0));
		// crossed limits, forward then reverse
		script_q.push_back(wr_row(pidc_pkg::REG_MIN_OUT, 16'd100));
		script_q.push_back(wr_row(pidc_pkg::REG_MAX_OUT, 16'hFF9C));
		script_q.push_back(item_row(16'sd1000, 1'b0, '0));
		script_q.push_back(item_row(16'sh8000, 1'b0, '0));
		script_q.push_back(wr_row(pidc_pkg::REG_REVERSE_MODE, 16'h0001));
		script_q.push_back(item_row(16'sd2000, 1'b0, '0));

		// reset once, inputs parked
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script_q[i]) begin
			if (script_q[i].is_wr) begin
				// settings only change with the pipe empty
				if (!cfg_open) begin
					wait_idle();
				end
				write_reg(script_q[i].idx, script_q[i].data);
			end else begin
				send_measure(script_q[i].meas, script_q[i].typed, script_q[i].want);
			end
		end

		// random phases: fresh settings each time, then a run of measurements
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			case ($urandom_range(0, 3))
				0: write_reg(pidc_pkg::REG_TARGET_VALUE,
					($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000);
				default: write_reg(pidc_pkg::REG_TARGET_VALUE,
					DATA_WIDTH'($urandom_range(0, 65535)));
			endcase
			write_reg(pidc_pkg::REG_PROP_GAIN, pick_gain());
			write_reg(pidc_pkg::REG_INTEG_GAIN, pick_gain());
			write_reg(pidc_pkg::REG_DERIV_GAIN, pick_gain());
			a = int'($urandom_range(0, 65535)) - 32768;
			b = int'($urandom_range(0, 65535)) - 32768;
			case ($urandom_range(0, 5))
				0: begin
					lo_pick = SAMPLE_MIN;
					hi_pick = SAMPLE_MAX;
				end
				1: begin
					// crossed window
					lo_pick = (a > b) ? a : b;
					hi_pick = (a > b) ? b : a;
				end
				2: begin
					lo_pick = (a < b) ? a : b;
					hi_pick = (a < b) ? b : a;
				end
				default: begin
					// window around the setpoint so the clamps actually bite
					lo_pick = int'(setpoint_q) - int'($urandom_range(0, 8000));
					hi_pick = int'(setpoint_q) + int'($urandom_range(0, 8000));
				end
			endcase
			write_reg(pidc_pkg::REG_MIN_OUT, to_sample(lo_pick));
			write_reg(pidc_pkg::REG_MAX_OUT, to_sample(hi_pick));
			// flag registers see junk in the upper data bits
			flag_word    = DATA_WIDTH'($urandom_range(0, 65535));
			flag_word[0] = ($urandom_range(0, 5) == 0);
			write_reg(pidc_pkg::REG_HOLD_OFF, flag_word);
			flag_word    = DATA_WIDTH'($urandom_range(0, 65535));
			write_reg(pidc_pkg::REG_REVERSE_MODE, flag_word);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_measure(pick_measure(), 1'b0, '0);
			end
		end

		// drain, then give stray results a chance to show up
		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("pid_controller_clamped_core verification clean");
		end else begin
			$display("pid_controller_clamped_core verification failed");
		end
		$finish;
	end

endmodule
